// File: rtl/bts_pkg.sv
package bts_pkg;

  localparam int COLOR_W = 16;
  localparam int TEXEL_W = 3 * COLOR_W;
  localparam int COORD_W = 18;
  localparam int CFG_W   = 9;

  // input word modes; code 3 is handled as bilinear
  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_NEAREST  = 2'd1;
  localparam logic [1:0] MODE_BILINEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_TEX_WIDTH  = 1'b0;
  localparam logic CFG_TEX_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC_S,
    ST_LOC_T,
    ST_LOC_Y,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_MIX0,
    ST_MIX1,
    ST_DONE
  } state_t;

  // shared MAC control
  typedef struct packed {
    logic en;        // update accumulators
    logic accum;     // add product to accumulator, else overwrite
    logic save_row;  // copy accumulator to row register
    logic use_row;   // multiplicand is the row register, else texel color
  } mac_ctl_t;

endpackage

// File: rtl/bts_texmem.sv
module bts_texmem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [bts_pkg::TEXEL_W-1:0] wdata,
  output logic [bts_pkg::TEXEL_W-1:0] rdata
);

  logic [bts_pkg::TEXEL_W-1:0] mem [DEPTH];

  // single port: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/bts_locate.sv
module bts_locate #(
  parameter int FRAC_BITS = 16,
  parameter int IW        = 8
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bts_pkg::COORD_W-1:0]  coord,
  input  logic [bts_pkg::CFG_W-1:0]           size,
  output logic [IW-1:0]                       idx,
  output logic [FRAC_BITS-1:0]                frac
);

  localparam int PW = bts_pkg::COORD_W + bts_pkg::CFG_W + 1;

  logic signed [PW-1:0]        prod;
  logic [bts_pkg::CFG_W-1:0]   size_r;
  logic signed [PW-1:0]        idx_full;
  logic signed [PW-1:0]        lim;
  logic [bts_pkg::CFG_W-1:0]   size_m1;
  logic                        neg;
  logic                        over;

  // scale by size; result read back the next cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= coord * $signed({1'b0, size});
      size_r <= size;
    end
  end

  always_comb begin
    size_m1  = size_r - bts_pkg::CFG_W'(1);
    idx_full = prod >>> FRAC_BITS;
    lim      = $signed({{(PW - bts_pkg::CFG_W){1'b0}}, size_m1});
    neg      = prod[PW-1];
    over     = idx_full > lim;
    if (neg) begin
      idx  = '0;
      frac = '0;
    end else if (over) begin
      idx  = IW'(size_m1);
      frac = '0;
    end else begin
      idx  = idx_full[IW-1:0];
      frac = prod[FRAC_BITS-1:0];
    end
  end

endmodule

// File: rtl/bts_mac.sv
module bts_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  bts_pkg::mac_ctl_t           ctl,
  input  logic [bts_pkg::TEXEL_W-1:0] texel,
  input  logic [FRAC_BITS:0]          weight,
  output logic [bts_pkg::TEXEL_W-1:0] result
);

  localparam int CW   = bts_pkg::COLOR_W;
  localparam int AW   = CW + FRAC_BITS;
  localparam int ACCW = AW + FRAC_BITS + 1;

  logic [ACCW-1:0] acc  [3];
  logic [AW-1:0]   row  [3];
  logic [AW-1:0]   opa  [3];
  logic [ACCW-1:0] prod [3];

  // lane 0 red, lane 1 green, lane 2 blue
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[k]  = ctl.use_row ? row[k]
                            : AW'(texel[(2 - k) * CW +: CW]);
      prod[k] = ACCW'(opa[k]) * ACCW'(weight);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ctl.en) begin
        acc[k] <= ctl.accum ? acc[k] + prod[k] : prod[k];
      end
      if (ctl.save_row) begin
        row[k] <= acc[k][AW-1:0];
      end
    end
  end

  // weights carry 2*FRAC_BITS fraction bits after both passes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      result[(2 - k) * CW +: CW] = acc[k][2 * FRAC_BITS +: CW];
    end
  end

endmodule

// File: rtl/bilinear_texture_sampler.sv
// Channel  Handshake            Word contents
// -------  -------------------  ------------------------------------------------
// in       in_valid / in_stall  mode, load_x, load_y, load_rgb, coord_s, coord_t
// out      out_valid/out_stall  out_red, out_green, out_blue
// cfg      cfg_write            cfg_index (0 width, 1 height), cfg_data
//
// A load word is written to the texel memory on the cycle it is accepted, so
// loads stream at one per cycle while no read holds in_stall high. A read's
// steps are set by the sequencer around one locate multiplier (s then t) and
// the single-port texel memory feeding one three-lane MAC (four texel passes,
// two row-mix passes). in_stall is high while a read is in flight.
// rst is synchronous and clears the sequencer, output valid and the size
// registers (256 x 256); texel contents are undefined until loaded.
// A finished result waits in the output register; the next word can be
// accepted meanwhile, and a second result waits until the first is taken.
module bilinear_texture_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [7:0]                          load_x,
  input  logic [7:0]                          load_y,
  input  logic [bts_pkg::COLOR_W-1:0]         load_red,
  input  logic [bts_pkg::COLOR_W-1:0]         load_green,
  input  logic [bts_pkg::COLOR_W-1:0]         load_blue,
  input  logic signed [bts_pkg::COORD_W-1:0]  coord_s,
  input  logic signed [bts_pkg::COORD_W-1:0]  coord_t,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bts_pkg::COLOR_W-1:0]         out_red,
  output logic [bts_pkg::COLOR_W-1:0]         out_green,
  output logic [bts_pkg::COLOR_W-1:0]         out_blue,
  // configuration
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int IW    = (XW > YW) ? XW : YW;
  localparam int CMPW  = ((IW > bts_pkg::CFG_W) ? IW : bts_pkg::CFG_W) + 1;
  localparam int CW    = bts_pkg::COLOR_W;

  bts_pkg::state_t state, state_next;

  logic [bts_pkg::CFG_W-1:0]            tex_width, tex_height;
  logic [bts_pkg::CFG_W-1:0]            w_eff, h_eff;
  logic [1:0]                           mode_r;
  logic signed [bts_pkg::COORD_W-1:0]   s_r, t_r;
  logic                                 accept;
  logic                                 is_near;

  logic [XW-1:0]                        x0, x1, ax;
  logic [YW-1:0]                        y0, y1, ay;
  logic [FRAC_BITS-1:0]                 fx, fy;
  logic [CMPW-1:0]                      x0p1, y0p1;

  logic                                 loc_en;
  logic                                 loc_sel_t;
  logic signed [bts_pkg::COORD_W-1:0]   loc_coord;
  logic [bts_pkg::CFG_W-1:0]            loc_size;
  logic [IW-1:0]                        loc_idx;
  logic [FRAC_BITS-1:0]                 loc_frac;

  logic                                 mem_we, mem_re;
  logic [AW-1:0]                        mem_addr, load_addr, rd_addr;
  logic [bts_pkg::TEXEL_W-1:0]          mem_rdata;

  bts_pkg::mac_ctl_t                    mac_ctl;
  logic [FRAC_BITS:0]                   mac_w;
  logic [FRAC_BITS:0]                   one_fx, one_fy;
  logic [bts_pkg::TEXEL_W-1:0]          mac_result;

  logic                                 out_free;
  logic                                 out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != bts_pkg::ST_IDLE);
  assign is_near  = (mode_r == bts_pkg::MODE_NEAREST);
  assign out_free = !out_valid || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= bts_pkg::CFG_W'(256);
      tex_height <= bts_pkg::CFG_W'(256);
    end else if (cfg_write) begin
      if (cfg_index == bts_pkg::CFG_TEX_WIDTH) begin
        tex_width <= cfg_data;
      end
      if (cfg_index == bts_pkg::CFG_TEX_HEIGHT) begin
        tex_height <= cfg_data;
      end
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (tex_width == '0) begin
      w_eff = bts_pkg::CFG_W'(1);
    end else if (32'(tex_width) > MAX_WIDTH) begin
      w_eff = bts_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = tex_width;
    end
    if (tex_height == '0) begin
      h_eff = bts_pkg::CFG_W'(1);
    end else if (32'(tex_height) > MAX_HEIGHT) begin
      h_eff = bts_pkg::CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = tex_height;
    end
  end

  // capture read word
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      s_r    <= coord_s;
      t_r    <= coord_t;
    end
  end

  // locate: s in ST_LOC_S, t in ST_LOC_T, each result read in the next cycle
  assign loc_coord = loc_sel_t ? t_r : s_r;
  assign loc_size  = loc_sel_t ? h_eff : w_eff;

  bts_locate #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW)
  ) u_locate (
    .clk   (clk),
    .en    (loc_en),
    .coord (loc_coord),
    .size  (loc_size),
    .idx   (loc_idx),
    .frac  (loc_frac)
  );

  always_ff @(posedge clk) begin
    if (state == bts_pkg::ST_LOC_T) begin
      x0 <= XW'(loc_idx);
      fx <= loc_frac;
    end
    if (state == bts_pkg::ST_LOC_Y) begin
      y0 <= YW'(loc_idx);
      fy <= loc_frac;
    end
  end

  // right and bottom neighbors clamp to the edge
  always_comb begin
    x0p1 = CMPW'(x0) + CMPW'(1);
    y0p1 = CMPW'(y0) + CMPW'(1);
    x1   = (x0p1 < CMPW'(w_eff)) ? XW'(x0p1) : XW'(w_eff - bts_pkg::CFG_W'(1));
    y1   = (y0p1 < CMPW'(h_eff)) ? YW'(y0p1) : YW'(h_eff - bts_pkg::CFG_W'(1));
  end

  // texel memory port
  always_comb begin
    ax = ((state == bts_pkg::ST_RD1) || (state == bts_pkg::ST_RD3)) ? x1 : x0;
    ay = ((state == bts_pkg::ST_RD2) || (state == bts_pkg::ST_RD3)) ? y1 : y0;
    rd_addr   = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);
    load_addr = AW'(load_y) * AW'(MAX_WIDTH) + AW'(load_x);
    mem_we    = accept && (mode == bts_pkg::MODE_LOAD)
                && (32'(load_x) < MAX_WIDTH) && (32'(load_y) < MAX_HEIGHT);
    mem_addr  = (state == bts_pkg::ST_IDLE) ? load_addr : rd_addr;
  end

  bts_texmem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_texmem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata ({load_red, load_green, load_blue}),
    .rdata (mem_rdata)
  );

  assign one_fx = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  assign one_fy = one_fx;

  bts_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .texel  (mem_rdata),
    .weight (mac_w),
    .result (mac_result)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bts_pkg::ST_IDLE: begin
        if (accept && (mode != bts_pkg::MODE_LOAD)) begin
          state_next = bts_pkg::ST_LOC_S;
        end
      end
      bts_pkg::ST_LOC_S: state_next = bts_pkg::ST_LOC_T;
      bts_pkg::ST_LOC_T: state_next = bts_pkg::ST_LOC_Y;
      bts_pkg::ST_LOC_Y: state_next = bts_pkg::ST_RD0;
      bts_pkg::ST_RD0:   state_next = bts_pkg::ST_RD1;
      bts_pkg::ST_RD1:   state_next = is_near ? bts_pkg::ST_DONE : bts_pkg::ST_RD2;
      bts_pkg::ST_RD2:   state_next = bts_pkg::ST_RD3;
      bts_pkg::ST_RD3:   state_next = bts_pkg::ST_RD4;
      bts_pkg::ST_RD4:   state_next = bts_pkg::ST_MIX0;
      bts_pkg::ST_MIX0:  state_next = bts_pkg::ST_MIX1;
      bts_pkg::ST_MIX1:  state_next = bts_pkg::ST_DONE;
      bts_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bts_pkg::ST_IDLE;
        end
      end
      default: state_next = bts_pkg::ST_IDLE;
    endcase
  end

  // MAC schedule: rdata holds texel k in the cycle after its address
  always_comb begin
    loc_en    = 1'b0;
    loc_sel_t = 1'b0;
    mem_re    = 1'b0;
    mac_ctl   = '0;
    mac_w     = one_fx - (FRAC_BITS + 1)'(fx);
    out_load  = 1'b0;
    unique case (state)
      bts_pkg::ST_IDLE: ;
      bts_pkg::ST_LOC_S: begin
        loc_en = 1'b1;
      end
      bts_pkg::ST_LOC_T: begin
        loc_en    = 1'b1;
        loc_sel_t = 1'b1;
      end
      bts_pkg::ST_LOC_Y: ;
      bts_pkg::ST_RD0: begin
        mem_re = 1'b1;
      end
      bts_pkg::ST_RD1: begin
        mem_re     = !is_near;
        mac_ctl.en = !is_near;
      end
      bts_pkg::ST_RD2: begin
        mem_re        = 1'b1;
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_w         = (FRAC_BITS + 1)'(fx);
      end
      bts_pkg::ST_RD3: begin
        mem_re           = 1'b1;
        mac_ctl.en       = 1'b1;
        mac_ctl.save_row = 1'b1;
      end
      bts_pkg::ST_RD4: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_w         = (FRAC_BITS + 1)'(fx);
      end
      bts_pkg::ST_MIX0: begin
        mac_ctl.en       = 1'b1;
        mac_ctl.save_row = 1'b1;
        mac_ctl.use_row  = 1'b1;
        mac_w            = one_fy - (FRAC_BITS + 1)'(fy);
      end
      bts_pkg::ST_MIX1: begin
        mac_ctl.en      = 1'b1;
        mac_ctl.accum   = 1'b1;
        mac_ctl.use_row = 1'b1;
        mac_w           = (FRAC_BITS + 1)'(fy);
      end
      bts_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_near) begin
        out_red   <= mem_rdata[2 * CW +: CW];
        out_green <= mem_rdata[CW +: CW];
        out_blue  <= mem_rdata[0 +: CW];
      end else begin
        out_red   <= mac_result[2 * CW +: CW];
        out_green <= mac_result[CW +: CW];
        out_blue  <= mac_result[0 +: CW];
      end
    end
  end

endmodule

// File: test/tb_bilinear_texture_sampler.sv
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int FRAC        = 16;
  localparam int DRAIN       = 24;      // idle cycles waited after the last result
  localparam int LIMIT       = 800000;  // cycles before the run is called hung

  // mode code 3 is decoded as a bilinear read
  localparam logic [1:0] MODE_BILINEAR_ALT = 2'd3;

  typedef struct packed {
    logic [bts_pkg::COLOR_W-1:0] red;
    logic [bts_pkg::COLOR_W-1:0] green;
    logic [bts_pkg::COLOR_W-1:0] blue;
  } rgb_t;

  // ------------------------------------------------------------------------
  // DUT ports
  // ------------------------------------------------------------------------
  logic                                clk;
  logic                                rst        = 1'b1;
  logic                                in_valid   = 1'b0;
  logic                                in_stall;
  logic [1:0]                          mode       = bts_pkg::MODE_LOAD;
  logic [7:0]                          load_x     = '0;
  logic [7:0]                          load_y     = '0;
  logic [bts_pkg::COLOR_W-1:0]         load_red   = '0;
  logic [bts_pkg::COLOR_W-1:0]         load_green = '0;
  logic [bts_pkg::COLOR_W-1:0]         load_blue  = '0;
  logic signed [bts_pkg::COORD_W-1:0]  coord_s    = '0;
  logic signed [bts_pkg::COORD_W-1:0]  coord_t    = '0;
  logic                                out_valid;
  logic                                out_stall  = 1'b0;
  logic [bts_pkg::COLOR_W-1:0]         out_red;
  logic [bts_pkg::COLOR_W-1:0]         out_green;
  logic [bts_pkg::COLOR_W-1:0]         out_blue;
  logic                                cfg_write  = 1'b0;
  logic                                cfg_index  = bts_pkg::CFG_TEX_WIDTH;
  logic [bts_pkg::CFG_W-1:0]           cfg_data   = '0;

  bilinear_texture_sampler DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .load_x     (load_x),
    .load_y     (load_y),
    .load_red   (load_red),
    .load_green (load_green),
    .load_blue  (load_blue),
    .coord_s    (coord_s),
    .coord_t    (coord_t),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ------------------------------------------------------------------------
  // Predictor state: shadow texel memory plus the size registers.
  // written[] tracks which texels hold data, so a read never lands on a
  // texel the block has not seen loaded.
  // ------------------------------------------------------------------------
  rgb_t                       texels  [0:MAX_W*MAX_H-1];
  bit                         written [0:MAX_W*MAX_H-1];
  logic [bts_pkg::CFG_W-1:0]  width_reg  = 9'd256;
  logic [bts_pkg::CFG_W-1:0]  height_reg = 9'd256;

  rgb_t expected_colors[$];   // filtered colors waiting for the result port
  int   words_sent = 0;
  int   errors     = 0;
  int   cycles     = 0;
  bit   no_idle    = 1'b0;    // set for the back-to-back stretch

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // zero acts as one, anything past the store acts as the store size
  function automatic int eff_size(input logic [bts_pkg::CFG_W-1:0] r, input int maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return int'(r);
  endfunction

  // scale by size, floor, clamp to [0,size-1]; fraction zeroed when clamped
  function automatic void locate(input logic signed [bts_pkg::COORD_W-1:0] c,
                                 input int size,
                                 output int idx, output longint frac);
    longint scaled;
    longint f;
    longint i;
    scaled = longint'(c) * longint'(size);
    f      = scaled & 64'hFFFF;
    i      = (scaled - f) >>> FRAC;
    if (i < 0) begin
      idx  = 0;
      frac = 0;
    end else if (i > size - 1) begin
      idx  = size - 1;
      frac = 0;
    end else begin
      idx  = int'(i);
      frac = f;
    end
  endfunction

  // the four texel addresses a read touches (all equal for nearest) and the
  // fractional weights; neighbours stop at the right and bottom edge
  function automatic void footprint(input logic [1:0] op,
                                    input logic signed [bts_pkg::COORD_W-1:0] s, t,
                                    output int a0, a1, a2, a3,
                                    output longint fx, fy);
    int w, h, x0, y0, x1, y1;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    locate(s, w, x0, fx);
    locate(t, h, y0, fy);
    if (op == bts_pkg::MODE_NEAREST) begin
      x1 = x0;
      y1 = y0;
    end else begin
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    end
    a0 = y0 * MAX_W + x0;
    a1 = y0 * MAX_W + x1;
    a2 = y1 * MAX_W + x0;
    a3 = y1 * MAX_W + x1;
  endfunction

  function automatic rgb_t filter_texel(input logic [1:0] op,
                                        input logic signed [bts_pkg::COORD_W-1:0] s, t);
    int         a [4];
    longint     fx, fy;
    bit [63:0]  one;
    bit [63:0]  wt [4];
    bit [63:0]  acc_r, acc_g, acc_b;
    rgb_t       res;
    footprint(op, s, t, a[0], a[1], a[2], a[3], fx, fy);
    if (op == bts_pkg::MODE_NEAREST)
      return texels[a[0]];
    one   = 64'd1 << FRAC;
    wt[0] = (one - fx) * (one - fy);
    wt[1] = fx * (one - fy);
    wt[2] = (one - fx) * fy;
    wt[3] = fx * fy;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int k = 0; k < 4; k++) begin
      acc_r += 64'(texels[a[k]].red)   * wt[k];
      acc_g += 64'(texels[a[k]].green) * wt[k];
      acc_b += 64'(texels[a[k]].blue)  * wt[k];
    end
    // exact sum, truncated once
    res.red   = acc_r[2*FRAC +: bts_pkg::COLOR_W];
    res.green = acc_g[2*FRAC +: bts_pkg::COLOR_W];
    res.blue  = acc_b[2*FRAC +: bts_pkg::COLOR_W];
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Random helpers
  // ------------------------------------------------------------------------
  function automatic rgb_t random_color();
    rgb_t c;
    c = rgb_t'(48'({$urandom, $urandom}));
    case ($urandom_range(9))
      0: c = '0;
      1: c = '1;
      default: ;
    endcase
    return c;
  endfunction

  // mostly inside [0,1], some near the edges, some anywhere
  function automatic logic signed [bts_pkg::COORD_W-1:0] random_coord();
    int r;
    r = $urandom_range(99);
    if (r < 65) return bts_pkg::COORD_W'($urandom_range(0, 65535));
    if (r < 75) return bts_pkg::COORD_W'($urandom_range(65520, 65552));
    if (r < 82) return bts_pkg::COORD_W'($urandom_range(0, 24));
    if (r < 90) return bts_pkg::COORD_W'(-int'($urandom_range(1, 131072)));
    return bts_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [1:0] random_read_mode();
    int r;
    r = $urandom_range(9);
    if (r < 4) return bts_pkg::MODE_NEAREST;
    if (r < 9) return bts_pkg::MODE_BILINEAR;
    return MODE_BILINEAR_ALT;
  endfunction

  function automatic logic [bts_pkg::CFG_W-1:0] random_size();
    int r;
    r = $urandom_range(99);
    if (r < 35) return bts_pkg::CFG_W'($urandom_range(1, 8));
    if (r < 80) return bts_pkg::CFG_W'($urandom_range(1, 256));
    case ($urandom_range(4))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'd511;
      default: return bts_pkg::CFG_W'($urandom_range(257, 511));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------

  // Drives one word and holds it until accepted. Leaves valid high on return:
  // the caller drives the next word or lowers valid in the same time step.
  task automatic send_word(input logic [1:0] op, input logic [7:0] lx, ly,
                           input rgb_t color,
                           input logic signed [bts_pkg::COORD_W-1:0] s, t);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    load_x     <= lx;
    load_y     <= ly;
    load_red   <= color.red;
    load_green <= color.green;
    load_blue  <= color.blue;
    coord_s    <= s;
    coord_t    <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    // predictor moves at the accepting edge
    if (op == bts_pkg::MODE_LOAD) begin
      texels[{ly, lx}]  = color;
      written[{ly, lx}] = 1'b1;
    end else begin
      expected_colors.insert(expected_colors.size(), filter_texel(op, s, t));
    end
  endtask

  task automatic load_texel(input int x, y, input rgb_t color);
    send_word(bts_pkg::MODE_LOAD, 8'(x), 8'(y), color, random_coord(), random_coord());
  endtask

  // read, first loading any texel in its footprint that is still empty
  task automatic read_at(input logic [1:0] op,
                         input logic signed [bts_pkg::COORD_W-1:0] s, t);
    int     a [4];
    longint fx, fy;
    footprint(op, s, t, a[0], a[1], a[2], a[3], fx, fy);
    for (int k = 0; k < 4; k++)
      if (!written[a[k]])
        load_texel(a[k] % MAX_W, a[k] / MAX_W, random_color());
    send_word(op, 8'($urandom), 8'($urandom), random_color(), s, t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // size registers only change with the pipe empty
  task automatic write_size(input logic idx, input logic [bts_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == bts_pkg::CFG_TEX_WIDTH) width_reg = value;
    else                               height_reg = value;
  endtask

  // mix of loads and reads, loads mostly inside the active texture
  task automatic run_random(input int count);
    int stop_at;
    int w, h;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(3) == 0)
          load_texel($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1),
                     random_color());
        else
          load_texel($urandom_range(0, w - 1), $urandom_range(0, h - 1), random_color());
      end else begin
        read_at(random_read_mode(), random_coord(), random_coord());
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side: random stall, compare each accepted word with the oldest
  // prediction.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h %h %h",
                                  out_red, out_green, out_blue));
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("out_red %h, expected %h", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("out_green %h, expected %h", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("out_blue %h, expected %h", out_blue, want.blue));
      end
    end
    out_stall <= !no_idle && ($urandom_range(99) < 28);
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // 256x256 after reset: corners, clamping, edges, code 3, ignored fields
  task automatic test_directed();
    // loads carry extreme coordinates, which must be ignored
    send_word(bts_pkg::MODE_LOAD, 8'd0, 8'd0, '{16'hFFFF, 16'h0000, 16'hFFFF},
              -18'sd131072, 18'sd131071);
    send_word(bts_pkg::MODE_LOAD, 8'd255, 8'd255, '{16'h0000, 16'hFFFF, 16'h0000},
              18'sd131071, -18'sd131072);
    load_texel(128, 64, random_color());
    // nearest: origin, 1.0 and above clamp, negative clamp, just under 1.0
    read_at(bts_pkg::MODE_NEAREST, 18'sd0, 18'sd0);
    read_at(bts_pkg::MODE_NEAREST, 18'sd65536, 18'sd65536);
    read_at(bts_pkg::MODE_NEAREST, 18'sd131071, 18'sd131071);
    read_at(bts_pkg::MODE_NEAREST, -18'sd1, -18'sd131072);
    read_at(bts_pkg::MODE_NEAREST, 18'sd65535, 18'sd65535);
    // read with every load field at all ones, which must be ignored
    send_word(bts_pkg::MODE_NEAREST, 8'hFF, 8'hFF, '1, 18'sd0, 18'sd0);
    // bilinear: half texel in the middle, bottom-right neighbour clamp,
    // mixed clamps, code 3
    read_at(bts_pkg::MODE_BILINEAR, 18'sd32768 + 18'sd128, 18'sd16384 + 18'sd128);
    read_at(bts_pkg::MODE_BILINEAR, 18'sd65535, 18'sd65535);
    read_at(bts_pkg::MODE_BILINEAR, 18'sd0, 18'sd65535);
    read_at(bts_pkg::MODE_BILINEAR, -18'sd5, 18'sd70000);
    read_at(MODE_BILINEAR_ALT, 18'sd12345, 18'sd54321);
    read_at(bts_pkg::MODE_BILINEAR, 18'sd255, 18'sd257);
  endtask

  // one-texel texture, then zero sizes which act as one
  task automatic test_unit_texture();
    write_size(bts_pkg::CFG_TEX_WIDTH, 9'd1);
    write_size(bts_pkg::CFG_TEX_HEIGHT, 9'd1);
    run_random(150);
    write_size(bts_pkg::CFG_TEX_WIDTH, 9'd0);
    write_size(bts_pkg::CFG_TEX_HEIGHT, 9'd0);
    run_random(150);
  endtask

  // sizes past the store act as the full store
  task automatic test_oversize();
    write_size(bts_pkg::CFG_TEX_WIDTH, 9'd511);
    write_size(bts_pkg::CFG_TEX_HEIGHT, 9'd257);
    run_random(200);
  endtask

  task automatic test_random_sizes();
    for (int n = 0; n < 6; n++) begin
      write_size(bts_pkg::CFG_TEX_WIDTH, (n == 0) ? 9'd2 : random_size());
      write_size(bts_pkg::CFG_TEX_HEIGHT, (n == 0) ? 9'd2 : random_size());
      run_random(180);
    end
  endtask

  // no gaps on either side
  task automatic test_steady_stream();
    write_size(bts_pkg::CFG_TEX_WIDTH, 9'd256);
    write_size(bts_pkg::CFG_TEX_HEIGHT, 9'd3);
    no_idle = 1'b1;
    run_random(300);
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_unit_texture();
    test_oversize();
    test_random_sizes();
    test_steady_stream();
    wait_drained();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
